/* sv/tlba_pkg.sv */
`timescale 1ns / 1ps

package tlba_pkg;

	localparam int LEAF_BITS = 8;
	localparam int TOP_BITS  = 64;
	localparam int BIT_W     = $clog2(LEAF_BITS);
	localparam int WORD_W    = $clog2(TOP_BITS);
	localparam int SLOT_W    = WORD_W + BIT_W;
	localparam int MAXB_W    = SLOT_W + 1;

	typedef logic [LEAF_BITS-1:0] leaf_t;
	typedef logic [TOP_BITS-1:0]  sum_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [BIT_W-1:0]     bitn_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [MAXB_W-1:0]    maxb_t;
	typedef logic [3:0]           cmd_t;

	localparam cmd_t CMD_CLEAR     = 4'd0;
	localparam cmd_t CMD_LAZY_INIT = 4'd1;
	localparam cmd_t CMD_FREE_TICK = 4'd2;
	localparam cmd_t CMD_USED_TICK = 4'd3;
	localparam cmd_t CMD_SET       = 4'd4;
	localparam cmd_t CMD_CLEAR_BIT = 4'd5;
	localparam cmd_t CMD_GET       = 4'd6;
	localparam cmd_t CMD_FIND      = 4'd7;
	localparam cmd_t CMD_FIND_SET  = 4'd8;

	// request from the engine to the leaf memory
	typedef struct packed {
		logic  rd_en;
		word_t rd_addr;
		logic  wr_en;
		word_t wr_addr;
		leaf_t wr_data;
		logic  clr_en;
		sum_t  clr_mask;
	} leaf_req_t;

	typedef struct packed {
		slot_t slot_index;
		logic  found;
		logic  bit_value;
	} result_t;

	// index of the lowest zero bit of the summary
	function automatic word_t lowest_zero_top(sum_t v);
		word_t n;
		n = '0;
		for (int i = TOP_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				n = word_t'(i);
			end
		end
		return n;
	endfunction

	// index of the lowest zero bit of a leaf word
	function automatic bitn_t lowest_zero_leaf(leaf_t v);
		bitn_t n;
		n = '0;
		for (int i = LEAF_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				n = bitn_t'(i);
			end
		end
		return n;
	endfunction

endpackage

/* sv/two_level_bitmap_allocator.sv */
`timescale 1ns / 1ps

// channel  | signals                              | accepted when
// ---------+--------------------------------------+-----------------------
// in       | in_valid, in_ready, command,         | in_valid & in_ready
//          | bit_index                            |
// out      | out_valid, out_ready, slot_index,    | out_valid & out_ready
//          | found, bit_value                     |
// cfg      | cfg_valid, cfg_ready, cfg_data       | cfg_valid & cfg_ready
//
// every command issues its leaf word read at accept, then does the modify and
// write-back into the leaf memory
// clear needs no clearing pass: per-word valid bits drop in one step
// reset is immediate, with no clearing pass; all leaf words read as zero
// a full output register holds the engine in its write-back cycle

module two_level_bitmap_allocator
	import tlba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	// command items
	input  logic  in_valid,
	output logic  in_ready,
	input  cmd_t  command,
	input  slot_t bit_index,
	// result items
	output logic  out_valid,
	input  logic  out_ready,
	output slot_t slot_index,
	output logic  found,
	output logic  bit_value,
	// max_bits register write
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  maxb_t cfg_data
);

	maxb_t     max_bits_q;
	logic      out_valid_q;
	result_t   out_q;
	logic      out_free;
	logic      done;
	result_t   res;
	leaf_req_t req;
	leaf_t     rd_data;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bits_q <= maxb_t'(LEAF_BITS * TOP_BITS);
		end else if (cfg_valid) begin
			max_bits_q <= cfg_data;
		end
	end

	// output register is free when empty or draining this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = out_q.slot_index;
	assign found      = out_q.found;
	assign bit_value  = out_q.bit_value;

	// command decode, summary word and read-modify-write of one leaf
	tlba_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.bit_index (bit_index),
		.max_bits  (max_bits_q),
		.out_free  (out_free),
		.done      (done),
		.res       (res),
		.req       (req),
		.rd_data   (rd_data)
	);

	// leaf words, registered read data
	tlba_leaf_mem u_leaf_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

/* sv/tlba_leaf_mem.sv */
`timescale 1ns / 1ps

module tlba_leaf_mem
	import tlba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  leaf_req_t req,
	output leaf_t     rd_data
);

	leaf_t mem [TOP_BITS];
	sum_t  valid_q;
	leaf_t rd_data_q;

	// an entry not yet written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr_en) begin
			valid_q <= valid_q & ~req.clr_mask;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/tlba_engine.sv */
`timescale 1ns / 1ps

module tlba_engine
	import tlba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cmd_t      command,
	input  slot_t     bit_index,
	input  maxb_t     max_bits,
	input  logic      out_free,
	output logic      done,
	output result_t   res,
	output leaf_req_t req,
	input  leaf_t     rd_data
);

	logic  busy_q;
	cmd_t  cmd_q;
	slot_t idx_q;
	word_t fword_q;
	sum_t  summary_q;
	sum_t  sum_d;
	logic  accept;
	logic  is_find;

	assign in_ready = !busy_q;
	assign accept   = in_valid && !busy_q;
	assign done     = busy_q && out_free;
	assign is_find  = (command == CMD_FIND) || (command == CMD_FIND_SET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			summary_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q    <= 1'b0;
				summary_q <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			idx_q   <= bit_index;
			fword_q <= lowest_zero_top(summary_q);
		end
	end

	always_comb begin
		word_t word;
		bitn_t bitn;
		leaf_t mask;
		leaf_t wd;
		leaf_t nv;
		sum_t  sw;
		bitn_t fbit;
		slot_t fslot;
		logic  idx_ok;
		logic  wr;
		logic  clr;

		word   = idx_q[SLOT_W-1:BIT_W];
		bitn   = idx_q[BIT_W-1:0];
		mask   = leaf_t'(1) << bitn;
		idx_ok = {1'b0, idx_q} < max_bits;
		fbit   = lowest_zero_leaf(rd_data);
		fslot  = {fword_q, fbit};
		wd     = rd_data;
		nv     = rd_data;
		sw     = summary_q;
		wr     = 1'b0;
		clr    = 1'b0;
		sum_d  = summary_q;
		res    = '0;

		case (cmd_q)
			CMD_CLEAR: begin
				clr       = 1'b1;
				sum_d     = '0;
				res.found = 1'b1;
			end
			CMD_LAZY_INIT: begin
				sum_d     = '1;
				res.found = 1'b1;
			end
			CMD_FREE_TICK: begin
				if (idx_ok) begin
					wd = (bitn == '0) ? '1 : rd_data;
					nv = wd & ~mask;
					wr = 1'b1;
					if (wd == '1) begin
						sw    = (word == '0) ? '1 : summary_q;
						sum_d = sw & ~(sum_t'(1) << word);
					end
					res.found = 1'b1;
				end
			end
			CMD_USED_TICK: begin
				if (idx_ok) begin
					wd        = (bitn == '0) ? '1 : rd_data;
					nv        = wd | mask;
					wr        = 1'b1;
					res.found = 1'b1;
				end
			end
			CMD_SET: begin
				if (idx_ok) begin
					nv = rd_data | mask;
					wr = 1'b1;
					if (nv == '1) begin
						sum_d = summary_q | (sum_t'(1) << word);
					end
					res.found = 1'b1;
				end
			end
			CMD_CLEAR_BIT: begin
				if (idx_ok) begin
					nv = rd_data & ~mask;
					wr = 1'b1;
					if (rd_data == '1) begin
						sum_d = summary_q & ~(sum_t'(1) << word);
					end
					res.found = 1'b1;
				end
			end
			CMD_GET: begin
				if (idx_ok) begin
					res.bit_value = rd_data[bitn];
					res.found     = 1'b1;
				end
			end
			CMD_FIND, CMD_FIND_SET: begin
				word = fword_q;
				if (summary_q != '1 && rd_data != '1 && {1'b0, fslot} < max_bits) begin
					res.found      = 1'b1;
					res.slot_index = fslot;
					if (cmd_q == CMD_FIND_SET) begin
						nv = rd_data | (leaf_t'(1) << fbit);
						wr = 1'b1;
						if (nv == '1) begin
							sum_d = summary_q | (sum_t'(1) << fword_q);
						end
					end
				end
			end
			default: begin
			end
		endcase

		req.rd_en   = accept;
		req.rd_addr = is_find ? lowest_zero_top(summary_q) : bit_index[SLOT_W-1:BIT_W];
		req.wr_en   = wr && done;
		req.wr_addr = word;
		req.wr_data = nv;
		req.clr_en  = clr && done;
		for (int i = 0; i < TOP_BITS; i++) begin
			req.clr_mask[i] = (maxb_t'(i) << BIT_W) < max_bits;
		end
	end

endmodule

/* test/two_level_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps

module two_level_bitmap_allocator_tb;
	import tlba_pkg::*;

	// idling plan, switched on the number of items seen on each side
	localparam int MODE1_AT    = 590;
	localparam int MODE2_AT    = 1180;
	localparam int SEND_IDLE_A = 36;
	localparam int SEND_IDLE_B = 54;
	// long receiver hold-off so the block backs up into its input
	localparam int HOLD_AT     = 700;
	localparam int HOLD_LEN    = 300;
	// cycles with no handshake on any channel before giving up
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_PHASES  = 10;
	localparam int PHASE_ITEMS = 175;
	localparam int DRAIN_PHASE = 3;

	typedef struct {
		cmd_t  cmd;
		slot_t idx;
		logic  wait_drain;
	} alloc_req_t;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_ready;
	cmd_t  command   = CMD_CLEAR;
	slot_t bit_index = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	slot_t slot_index;
	logic  found;
	logic  bit_value;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	maxb_t cfg_data  = '0;

	// shadow copy of the allocator state
	sum_t  mdl_sum;
	leaf_t mdl_leaf [TOP_BITS];
	maxb_t mdl_max;

	alloc_req_t pending_items[$];
	result_t    result_q[$];
	int         n_in;
	int         n_out;
	int         queued;
	int         errors;
	int         stall_cycles;
	logic       drain_next;
	maxb_t      phase_max [NUM_PHASES];

	two_level_bitmap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.bit_index (bit_index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot_index(slot_index),
		.found     (found),
		.bit_value (bit_value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// apply one command to the shadow map and return the result it must give
	function automatic result_t apply_command(cmd_t c, slot_t idx);
		result_t r;
		word_t   w;
		bitn_t   b;
		word_t   fw;
		bitn_t   fb;
		leaf_t   wd;
		leaf_t   freeb;
		logic    ok;
		logic    hit;
		int      nw;
		int      s;
		r  = '0;
		w  = idx[SLOT_W-1:BIT_W];
		b  = idx[BIT_W-1:0];
		ok = idx < mdl_max;
		fw = '0;
		fb = '0;
		case (c)
			CMD_CLEAR: begin
				// only the words covered by max_bits are wiped
				nw = (int'(mdl_max) + LEAF_BITS - 1) / LEAF_BITS;
				if (nw > TOP_BITS) begin
					nw = TOP_BITS;
				end
				mdl_sum = '0;
				for (int i = 0; i < nw; i++) begin
					mdl_leaf[i] = '0;
				end
				r.found = 1'b1;
			end
			CMD_LAZY_INIT: begin
				mdl_sum = '1;
				r.found = 1'b1;
			end
			CMD_FREE_TICK: begin
				if (ok) begin
					// first slot of a word starts from an all-used word
					wd = (b == 0) ? '1 : mdl_leaf[w];
					mdl_leaf[w] = wd & ~(leaf_t'(1) << b);
					if (wd == '1) begin
						if (w == 0) begin
							mdl_sum = '1;
						end
						mdl_sum[w] = 1'b0;
					end
					r.found = 1'b1;
				end
			end
			CMD_USED_TICK: begin
				if (ok) begin
					wd = (b == 0) ? '1 : mdl_leaf[w];
					mdl_leaf[w] = wd | (leaf_t'(1) << b);
					r.found = 1'b1;
				end
			end
			CMD_SET: begin
				if (ok) begin
					mdl_leaf[w][b] = 1'b1;
					if (mdl_leaf[w] == '1) begin
						mdl_sum[w] = 1'b1;
					end
					r.found = 1'b1;
				end
			end
			CMD_CLEAR_BIT: begin
				if (ok) begin
					if (mdl_leaf[w] == '1) begin
						mdl_sum[w] = 1'b0;
					end
					mdl_leaf[w][b] = 1'b0;
					r.found = 1'b1;
				end
			end
			CMD_GET: begin
				if (ok) begin
					r.bit_value = mdl_leaf[w][b];
					r.found     = 1'b1;
				end
			end
			CMD_FIND, CMD_FIND_SET: begin
				if (mdl_sum != '1) begin
					hit = 1'b0;
					for (int i = 0; i < TOP_BITS; i++) begin
						if (!hit && !mdl_sum[i]) begin
							fw  = word_t'(i);
							hit = 1'b1;
						end
					end
					// the summary may point at a word that is really full
					freeb = ~mdl_leaf[fw];
					if (freeb != '0) begin
						hit = 1'b0;
						for (int i = 0; i < LEAF_BITS; i++) begin
							if (!hit && freeb[i]) begin
								fb  = bitn_t'(i);
								hit = 1'b1;
							end
						end
						s = int'(fw) * LEAF_BITS + int'(fb);
						if (s < int'(mdl_max)) begin
							if (c == CMD_FIND_SET) begin
								mdl_leaf[fw][fb] = 1'b1;
								if (mdl_leaf[fw] == '1) begin
									mdl_sum[fw] = 1'b1;
								end
							end
							r.slot_index = slot_t'(s);
							r.found      = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int idle_pct(int n, int first, int second);
		if (n < MODE1_AT) begin
			return first;
		end
		if (n < MODE2_AT) begin
			return second;
		end
		return 0;
	endfunction

	// command driver: offers queued items, predicts on every accept
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		alloc_req_t nxt;
		logic       acc;
		logic       go;
		int         outstanding;
		if (!arst_n) begin
			in_valid <= 1'b0;
			n_in     <= 0;
		end else begin
			acc = in_valid && in_ready;
			if (acc) begin
				result_q.push_back(apply_command(command, bit_index));
				n_in <= n_in + 1;
			end
			// a valid item that was not taken stays on the bus untouched
			if (!in_valid || acc) begin
				outstanding = n_in - n_out + (acc ? 1 : 0);
				go = pending_items.size() > 0 &&
					$urandom_range(0, 99) >= idle_pct(n_in, SEND_IDLE_A, SEND_IDLE_B);
				// sender pause: hold this item until every result is back
				if (go && pending_items[0].wait_drain && outstanding != 0) begin
					go = 1'b0;
				end
				if (go) begin
					nxt = pending_items.pop_front();
					in_valid  <= 1'b1;
					command   <= nxt.cmd;
					bit_index <= nxt.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares in order, drives ready with random stalls
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		result_t got;
		int      hold_left;
		logic    rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
			n_out     <= 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.slot_index = slot_index;
				got.found      = found;
				got.bit_value  = bit_value;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected item slot_index %0d found %0b bit_value %0b",
						$time, got.slot_index, got.found, got.bit_value);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (got.slot_index !== want.slot_index) begin
						$display("%0t: slot_index expected %0d actual %0d",
							$time, want.slot_index, got.slot_index);
						errors++;
					end
					if (got.found !== want.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, got.found);
						errors++;
					end
					if (got.bit_value !== want.bit_value) begin
						$display("%0t: bit_value expected %0b actual %0b",
							$time, want.bit_value, got.bit_value);
						errors++;
					end
				end
				if (n_out == HOLD_AT) begin
					hold_left = HOLD_LEN;
				end
				n_out <= n_out + 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				rdy = $urandom_range(0, 99) >= idle_pct(n_out, SEND_IDLE_B, SEND_IDLE_A);
			end
			out_ready <= rdy;
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic add_item(cmd_t c, slot_t i);
		alloc_req_t req;
		req.cmd        = c;
		req.idx        = i;
		req.wait_drain = drain_next;
		drain_next     = 1'b0;
		pending_items.push_back(req);
		queued++;
	endtask

	// mostly a slot below the limit, now and then anything
	function automatic slot_t any_slot(maxb_t lim);
		if (lim == 0 || $urandom_range(0, 9) == 0) begin
			return slot_t'($urandom_range(0, 511));
		end
		return slot_t'($urandom_range(0, int'(lim) - 1));
	endfunction

	function automatic slot_t junk_idx();
		return slot_t'($urandom_range(0, 511));
	endfunction

	// one short sequence of related commands
	task automatic add_episode(maxb_t lim);
		int    kind;
		int    k;
		int    r;
		int    base;
		int    top;
		slot_t s;
		kind = $urandom_range(0, 9);
		k    = $urandom_range(3, 24);
		case (kind)
			0, 1, 2: begin
				// allocation burst, with some frees and reads mixed in
				repeat (k) begin
					r = $urandom_range(0, 99);
					if (r < 65) begin
						add_item(CMD_FIND_SET, junk_idx());
					end else if (r < 75) begin
						add_item(CMD_FIND, junk_idx());
					end else if (r < 90) begin
						add_item(CMD_CLEAR_BIT, any_slot(lim));
					end else begin
						add_item(CMD_GET, any_slot(lim));
					end
				end
			end
			3, 4: begin
				// lazy set-up: init, then ticks over consecutive slots
				add_item(CMD_LAZY_INIT, junk_idx());
				base = 0;
				if (lim > LEAF_BITS && $urandom_range(0, 1) == 1) begin
					base = $urandom_range(0, (int'(lim) - 1) / LEAF_BITS) * LEAF_BITS;
				end
				top = base + k;
				if (top > 512) begin
					top = 512;
				end
				for (int n = base; n < top; n++) begin
					add_item(kind == 3 ? CMD_FREE_TICK : CMD_USED_TICK, slot_t'(n));
					if ($urandom_range(0, 7) == 0) begin
						add_item(CMD_FIND_SET, junk_idx());
					end
				end
				if (kind == 4) begin
					for (int n = base; n < base + k / 2 && n < 512; n++) begin
						add_item(CMD_FREE_TICK, slot_t'(n));
					end
				end
				add_item(CMD_FIND, junk_idx());
				add_item(CMD_FIND_SET, junk_idx());
			end
			5: begin
				repeat (k) begin
					add_item(cmd_t'($urandom_range(CMD_SET, CMD_GET)), any_slot(lim));
				end
			end
			6: begin
				// noise, unknown commands included
				repeat (k / 3 + 1) begin
					add_item(cmd_t'($urandom_range(0, 15)), junk_idx());
				end
			end
			7: begin
				add_item(CMD_CLEAR, junk_idx());
				repeat (k / 2) begin
					add_item(CMD_FIND_SET, junk_idx());
				end
			end
			8: begin
				// fill one word to make its summary bit flip both ways
				s = any_slot(lim);
				for (int n = 0; n < LEAF_BITS; n++) begin
					add_item(CMD_SET, {s[SLOT_W-1:BIT_W], bitn_t'(n)});
				end
				add_item(CMD_FIND, junk_idx());
				add_item(CMD_CLEAR_BIT, {s[SLOT_W-1:BIT_W], bitn_t'($urandom_range(0, 7))});
				add_item(CMD_FIND_SET, junk_idx());
			end
			default: begin
				// indices at or past the limit, any index once the limit covers all 512 slots
				repeat (3) begin
					if (lim < 512) begin
						s = slot_t'($urandom_range(int'(lim), 511));
					end else begin
						s = junk_idx();
					end
					add_item(cmd_t'($urandom_range(CMD_FREE_TICK, CMD_GET)), s);
				end
			end
		endcase
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_items.size() != 0 || in_valid || n_in != n_out ||
			result_q.size() != 0);
	endtask

	task automatic write_max_bits(maxb_t v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		mdl_max = v;
	endtask

	initial begin : stimulus
		maxb_t lim;
		int    start;
		mdl_sum    = '0;
		mdl_max    = maxb_t'(512);
		errors     = 0;
		queued     = 0;
		drain_next = 1'b0;
		for (int i = 0; i < TOP_BITS; i++) begin
			mdl_leaf[i] = '0;
		end
		phase_max = '{512, 9, 0, 1, 64, 100, 511, 8, 300, 512};
		phase_max[8] = maxb_t'($urandom_range(2, 511));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			// let the last write-back settle before touching the limit
			repeat (4) @(posedge clk);
			write_max_bits(phase_max[p]);
			@(negedge clk);
			lim = phase_max[p];
			if (p == 0) begin
				add_item(CMD_GET, slot_t'(0));
				add_item(CMD_FIND_SET, junk_idx());
				add_item(CMD_SET, slot_t'(511));
				add_item(CMD_GET, slot_t'(511));
				// map full after lazy init
				add_item(CMD_LAZY_INIT, slot_t'(0));
				add_item(CMD_FIND, slot_t'(511));
				// summary bit clear but word actually full
				add_item(CMD_FREE_TICK, slot_t'(0));
				add_item(CMD_USED_TICK, slot_t'(0));
				add_item(CMD_FIND, slot_t'(0));
				// top word freed lazily, but finds still land on the full word 0
				add_item(CMD_FREE_TICK, slot_t'(504));
				add_item(CMD_FREE_TICK, slot_t'(511));
				add_item(CMD_FIND_SET, junk_idx());
				add_item(CMD_FIND_SET, junk_idx());
				add_item(CMD_FIND, junk_idx());
				add_item(CMD_CLEAR, slot_t'(511));
				add_item(cmd_t'(9), slot_t'(511));
				add_item(cmd_t'(15), slot_t'(0));
			end else if (p == 1) begin
				// clear only covers two words, a get past the limit is not found
				add_item(CMD_CLEAR, junk_idx());
				add_item(CMD_GET, slot_t'(200));
			end else if (p == 2) begin
				add_item(CMD_FIND, junk_idx());
				add_item(CMD_SET, slot_t'(0));
			end
			start = queued;
			while (queued - start < PHASE_ITEMS) begin
				if (p == DRAIN_PHASE && queued - start >= PHASE_ITEMS / 2 &&
					queued - start < PHASE_ITEMS / 2 + 3) begin
					drain_next = 1'b1;
				end
				add_episode(lim);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* files.f */
sv/tlba_pkg.sv
sv/tlba_leaf_mem.sv
sv/tlba_engine.sv
sv/two_level_bitmap_allocator.sv
test/two_level_bitmap_allocator_tb.sv
